// File: sv/spd_pkg.sv
// Package for the shortest path block: widths, operation codes, key layout.
// No dependencies.
`default_nettype none
package spd_pkg;
  localparam int unsigned MaxNodes   = 64;
  localparam int unsigned MaxEdges   = 256;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned DistBits   = 24;
  localparam int unsigned NodeBits   = 6;
  localparam int unsigned CountBits  = 7;
  localparam int unsigned EdgeAw     = 8;
  localparam int unsigned EdgeCntW   = 9;
  localparam int unsigned HeapDepth  = MaxEdges + 1;
  localparam int unsigned HeapAw     = 9;
  localparam int unsigned KeyBits    = DistBits + NodeBits;
  localparam int unsigned EdgeBits   = 2 * NodeBits + WeightBits;

  typedef enum logic [1:0] {
    OpAddEdge = 2'd0,
    OpRun     = 2'd1,
    OpClear   = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef logic [KeyBits-1:0]  key_t;
  typedef logic [EdgeBits-1:0] edge_t;
  typedef logic [DistBits-1:0] dist_t;
endpackage
`default_nettype wire

// File: sv/spd_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on spd_pkg.
`default_nettype none
interface spd_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [spd_pkg::NodeBits-1:0]  from_node;
  logic [spd_pkg::NodeBits-1:0]  to_node;
  logic [spd_pkg::WeightBits-1:0] edge_weight;
  logic [spd_pkg::NodeBits-1:0]  source_node;
  modport source (output valid, operation, from_node, to_node, edge_weight, source_node,
                  input ready);
  modport sink (input valid, operation, from_node, to_node, edge_weight, source_node,
                output ready);
endinterface

interface spd_res_if;
  logic                         valid;
  logic                         ready;
  logic [spd_pkg::NodeBits-1:0] node_index;
  logic [spd_pkg::DistBits-1:0] node_distance;
  logic                         reachable;
  logic                         edges_dropped;
  logic                         last;
  modport source (output valid, node_index, node_distance, reachable, edges_dropped, last,
                  input ready);
  modport sink (input valid, node_index, node_distance, reachable, edges_dropped, last,
                output ready);
endinterface

interface spd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [spd_pkg::CountBits-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: sv/spd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module spd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned Aw    = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: sv/shortest_path_dijkstra.sv
// Top level of the shortest path block: sequencer around edge, heap and distance RAMs.
// Depends on spd_pkg, spd_if and spd_ram.
//
// Edge loads, clears and the unused operation code are taken while the block is
// idle and leave it idle, so such requests can follow back to back. A run request
// holds the request channel off until its last result has been accepted. During a
// run all heap and edge accesses go through RAMs with one write port and one
// registered read port. A pop passes StPopChk, StPopLast and StSdFetch, then StSdRd1,
// StSdRd2 and StSdCmp for each heap level that the moved entry sinks, and StVisit to
// finalize the vertex. Each finalized vertex then scans every stored edge in StEdChk.
// Each push passes StSuRd and StSuCmp for each level that it climbs, then StEdNext.
// Results start with StOutRd; each is loaded in StOutLd and held in StOutWait until the
// receiver takes it, so receiver stalls add directly. The edge scan dominates on dense graphs.
`default_nettype none
module shortest_path_dijkstra (
  input wire logic clk_i,
  input wire logic rst_ni,
  spd_cfg_if.sink  cfg_i,
  spd_req_if.sink  req_i,
  spd_res_if.source res_o
);
  typedef enum logic [14:0] {
    StIdle    = 15'b000000000000001,
    StPopChk  = 15'b000000000000010,
    StPopLast = 15'b000000000000100,
    StSdFetch = 15'b000000000001000,
    StSdRd1   = 15'b000000000010000,
    StSdRd2   = 15'b000000000100000,
    StSdCmp   = 15'b000000001000000,
    StVisit   = 15'b000000010000000,
    StEdChk   = 15'b000000100000000,
    StSuRd    = 15'b000001000000000,
    StSuCmp   = 15'b000010000000000,
    StEdNext  = 15'b000100000000000,
    StOutRd   = 15'b001000000000000,
    StOutLd   = 15'b010000000000000,
    StOutWait = 15'b100000000000000
  } state_e;

  localparam int unsigned Nb = spd_pkg::NodeBits;
  localparam int unsigned Cb = spd_pkg::CountBits;
  localparam int unsigned Hw = spd_pkg::HeapAw;
  localparam int unsigned Db = spd_pkg::DistBits;
  localparam int unsigned Ew = spd_pkg::EdgeCntW;
  localparam logic [Db-1:0] DistMax = '1;

  state_e state_q, state_d;
  logic [Cb-1:0]  ncount_q;
  logic [Ew-1:0]  etotal_q;
  logic           drop_q;
  logic [Hw-1:0]  hsize_q;
  logic [spd_pkg::MaxNodes-1:0] vis_q;
  logic [Cb-1:0]  n_q;
  logic [Ew-1:0]  eidx_q;
  logic [Hw-1:0]  hi_q;
  spd_pkg::key_t  key_q, ca_q, top_q;
  logic [Cb-1:0]  oi_q;
  logic           rvalid_q;
  logic [Nb-1:0]  ridx_q;
  logic [Db-1:0]  rdist_q;
  logic           rreach_q, rlast_q;

  // Edge RAM
  logic                        e_we;
  logic [spd_pkg::EdgeAw-1:0]  e_ra;
  spd_pkg::edge_t              e_rd;
  // Heap RAM
  logic                        h_we;
  logic [Hw-1:0]               h_wa, h_ra;
  spd_pkg::key_t               h_wd, h_rd;
  // Distance RAM
  logic                        d_we;
  logic [Nb-1:0]               d_ra;
  logic [Db-1:0]               d_rd;

  // Vertex being finalized and its distance, taken from the popped key.
  logic [Nb-1:0] top_v;
  logic [Db-1:0] top_d;
  assign top_v = top_q[Nb-1:0];
  assign top_d = top_q[spd_pkg::KeyBits-1:Nb];

  spd_ram #(.Width(spd_pkg::EdgeBits), .Depth(spd_pkg::MaxEdges), .Aw(spd_pkg::EdgeAw))
  u_edge (
    .clk_i, .we_i(e_we), .waddr_i(etotal_q[spd_pkg::EdgeAw-1:0]),
    .wdata_i({req_i.from_node, req_i.to_node, req_i.edge_weight}),
    .raddr_i(e_ra), .rdata_o(e_rd)
  );
  spd_ram #(.Width(spd_pkg::KeyBits), .Depth(spd_pkg::HeapDepth), .Aw(Hw)) u_heap (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd)
  );
  spd_ram #(.Width(Db), .Depth(spd_pkg::MaxNodes), .Aw(Nb)) u_dist (
    .clk_i, .we_i(d_we), .waddr_i(top_v), .wdata_i(top_d), .raddr_i(d_ra), .rdata_o(d_rd)
  );

  logic [Cb-1:0] nact;
  always_comb begin
    nact = (ncount_q == '0) ? Cb'(1) :
           (ncount_q > Cb'(spd_pkg::MaxNodes)) ? Cb'(spd_pkg::MaxNodes) :
           ncount_q;
  end

  logic req_fire, cfg_fire, res_fire;
  assign req_i.ready = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign req_fire = req_i.valid && req_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign res_fire = rvalid_q && res_o.ready;

  logic edge_ok, src_ok;
  assign edge_ok = ({1'b0, req_i.from_node} < nact) && ({1'b0, req_i.to_node} < nact) &&
                   (etotal_q < Ew'(spd_pkg::MaxEdges));
  assign src_ok = ({1'b0, req_i.source_node} < nact);

  // Edge fields and candidate distance.
  logic [Nb-1:0] e_tail, e_head;
  logic [spd_pkg::WeightBits-1:0] e_w;
  logic [Db:0] nd_sum;
  logic [Db-1:0] nd;
  logic edge_hit;
  logic [Ew-1:0] eidx_next;
  assign {e_tail, e_head, e_w} = e_rd;
  assign nd_sum = {1'b0, top_d} + (Db+1)'(e_w);
  assign nd = nd_sum[Db] ? DistMax : nd_sum[Db-1:0];
  assign edge_hit = (e_tail == top_v) && ({1'b0, e_head} < n_q) && !vis_q[e_head];
  assign eidx_next = eidx_q + Ew'(1);

  logic seen;
  assign seen = ({1'b0, top_v} >= n_q) || vis_q[top_v];

  // Heap index arithmetic; children exist only below index 256, so the
  // shifted index never loses its top bit.
  logic [Hw-1:0] parent, child1, child2, best_idx;
  spd_pkg::key_t best_key;
  assign parent = (hi_q - Hw'(1)) >> 1;
  assign child1 = {hi_q[Hw-2:0], 1'b1};
  assign child2 = child1 + Hw'(1);
  // In StSdCmp the read data holds the right child and ca_q the left one.
  assign best_idx = (child2 < hsize_q && h_rd < ca_q) ? child2 : child1;
  assign best_key = (child2 < hsize_q && h_rd < ca_q) ? h_rd : ca_q;

  always_comb begin
    state_d = state_q;
    e_we = 1'b0;
    e_ra = eidx_q[spd_pkg::EdgeAw-1:0];
    h_we = 1'b0;
    h_wa = hi_q;
    h_wd = key_q;
    h_ra = '0;
    d_we = 1'b0;
    d_ra = oi_q[Nb-1:0];
    case (state_q)
      StIdle: begin
        if (req_fire) begin
          case (req_i.operation)
            spd_pkg::OpAddEdge: e_we = edge_ok;
            spd_pkg::OpRun: begin
              if (src_ok) begin
                h_we = 1'b1;
                h_wa = '0;
                h_wd = {{Db{1'b0}}, req_i.source_node};
                state_d = StPopChk;
              end else begin
                state_d = StOutRd;
              end
            end
            default: ;
          endcase
        end
      end
      StPopChk: begin
        state_d = (hsize_q == '0) ? StOutRd : StPopLast;
      end
      StPopLast: begin
        h_ra = hsize_q - Hw'(1);
        state_d = StSdFetch;
      end
      StSdFetch: state_d = StSdRd1;
      StSdRd1: begin
        if (child1 >= hsize_q) begin
          h_we = (hsize_q != '0);
          state_d = StVisit;
        end else begin
          h_ra = child1;
          state_d = StSdRd2;
        end
      end
      StSdRd2: begin
        h_ra = child2;
        state_d = StSdCmp;
      end
      StSdCmp: begin
        h_we = 1'b1;
        if (key_q <= best_key) begin
          state_d = StVisit;
        end else begin
          h_wd = best_key;
          state_d = StSdRd1;
        end
      end
      StVisit: begin
        if (seen) begin
          state_d = StPopChk;
        end else begin
          d_we = 1'b1;
          e_ra = '0;
          state_d = (etotal_q == '0) ? StPopChk : StEdChk;
        end
      end
      StEdChk: begin
        if (edge_hit) begin
          state_d = StSuRd;
        end else if (eidx_next >= etotal_q) begin
          state_d = StPopChk;
        end else begin
          e_ra = eidx_next[spd_pkg::EdgeAw-1:0];
        end
      end
      StSuRd: begin
        if (hi_q == '0) begin
          h_we = 1'b1;
          state_d = StEdNext;
        end else begin
          h_ra = parent;
          state_d = StSuCmp;
        end
      end
      StSuCmp: begin
        h_we = 1'b1;
        if (h_rd <= key_q) begin
          state_d = StEdNext;
        end else begin
          h_wd = h_rd;
          state_d = StSuRd;
        end
      end
      StEdNext: begin
        if (eidx_next >= etotal_q) begin
          state_d = StPopChk;
        end else begin
          e_ra = eidx_next[spd_pkg::EdgeAw-1:0];
          state_d = StEdChk;
        end
      end
      StOutRd: state_d = StOutLd;
      StOutLd: state_d = StOutWait;
      StOutWait: begin
        if (res_fire) state_d = rlast_q ? StIdle : StOutLd;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ncount_q <= Cb'(spd_pkg::MaxNodes);
      etotal_q <= '0;
      drop_q   <= 1'b0;
      hsize_q  <= '0;
      vis_q    <= '0;
      n_q      <= '0;
      eidx_q   <= '0;
      hi_q     <= '0;
      key_q    <= '0;
      ca_q     <= '0;
      top_q    <= '0;
      oi_q     <= '0;
      rvalid_q <= 1'b0;
      ridx_q   <= '0;
      rdist_q  <= '0;
      rreach_q <= 1'b0;
      rlast_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_fire) ncount_q <= cfg_i.data;
      case (state_q)
        StIdle: begin
          if (req_fire) begin
            case (req_i.operation)
              spd_pkg::OpAddEdge: begin
                if (edge_ok) etotal_q <= etotal_q + Ew'(1);
                else drop_q <= 1'b1;
              end
              spd_pkg::OpClear: begin
                etotal_q <= '0;
                drop_q   <= 1'b0;
              end
              spd_pkg::OpRun: begin
                vis_q   <= '0;
                oi_q    <= '0;
                n_q     <= nact;
                hsize_q <= src_ok ? Hw'(1) : '0;
              end
              default: ;
            endcase
          end
        end
        StPopLast: begin
          top_q   <= h_rd;
          hsize_q <= hsize_q - Hw'(1);
        end
        // The last heap entry becomes the key that sinks from the root.
        StSdFetch: begin
          key_q <= h_rd;
          hi_q  <= '0;
        end
        StSdRd2: ca_q <= h_rd;
        StSdCmp: begin
          if (!(key_q <= best_key)) hi_q <= best_idx;
        end
        StVisit: begin
          if (!seen) vis_q[top_v] <= 1'b1;
          eidx_q <= '0;
        end
        // At most one push per stored edge plus the source, so the heap cannot overflow.
        StEdChk: begin
          if (edge_hit) begin
            key_q   <= {nd, e_head};
            hi_q    <= hsize_q;
            hsize_q <= hsize_q + Hw'(1);
          end else begin
            eidx_q <= eidx_next;
          end
        end
        StSuCmp: begin
          if (!(h_rd <= key_q)) hi_q <= parent;
        end
        StEdNext: eidx_q <= eidx_next;
        StOutLd: begin
          rvalid_q <= 1'b1;
          ridx_q   <= oi_q[Nb-1:0];
          rreach_q <= vis_q[oi_q[Nb-1:0]];
          rdist_q  <= vis_q[oi_q[Nb-1:0]] ? d_rd : '0;
          rlast_q  <= (oi_q + Cb'(1) == n_q);
          oi_q     <= oi_q + Cb'(1);
        end
        StOutWait: begin
          if (res_fire) rvalid_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign res_o.valid         = rvalid_q;
  assign res_o.node_index    = ridx_q;
  assign res_o.node_distance = rdist_q;
  assign res_o.reachable     = rreach_q;
  assign res_o.edges_dropped = drop_q;
  assign res_o.last          = rlast_q;
endmodule
`default_nettype wire
